[rtl/core/bkt_pkg.sv]
package bkt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PIXEL_BITS = 12;
	localparam int POS_W = 32;
	localparam int COV_W = 40;
	localparam int REG_W = 24;
	localparam int PIX_OUT_W = 14;
	localparam int AGE_W = 16;
	localparam int MAG_W = 64;
	localparam int DIV_NUM_W = COV_W + FRAC_BITS;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_PREDICT = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_PROCESS_NOISE     = 2'd0,
		REG_MEASUREMENT_NOISE = 2'd1,
		REG_INITIAL_VARIANCE  = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PRED,
		ST_UPD_CHK,
		ST_DIV0_GO,
		ST_DIV0_WAIT,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_MUL_WB,
		ST_UPD_WB,
		ST_NEXT,
		ST_OUT_CALC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [COV_W-1:0]     num;
		logic [COV_W:0]       den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [POS_W-1:0]     gain;
	} div_rsp_t;

	typedef struct packed {
		logic                 start;
		logic signed [COV_W:0] a;
		logic signed [COV_W:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [MAG_W-1:0] prod;
	} mul_rsp_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MAG_W-1:0] v);
		logic signed [MAG_W-1:0] hi;
		logic signed [MAG_W-1:0] lo;
		begin
			hi = (MAG_W)'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
			lo = -hi - 64'sd1;
			if (v > hi) sat_pos = hi[POS_W-1:0];
			else if (v < lo) sat_pos = lo[POS_W-1:0];
			else sat_pos = v[POS_W-1:0];
		end
	endfunction

	function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [MAG_W-1:0] v);
		logic signed [MAG_W-1:0] hi;
		logic signed [MAG_W-1:0] lo;
		begin
			hi = (MAG_W)'((64'sd1 <<< (COV_W - 1)) - 64'sd1);
			lo = -hi - 64'sd1;
			if (v > hi) sat_cov = hi[COV_W-1:0];
			else if (v < lo) sat_cov = lo[COV_W-1:0];
			else sat_cov = v[COV_W-1:0];
		end
	endfunction

	function automatic logic [PIX_OUT_W-1:0] out_pix(input logic signed [MAG_W-1:0] v,
			input logic odd);
		logic [MAG_W-1:0] m;
		logic signed [MAG_W-1:0] s;
		begin
			m = v[MAG_W-1] ? (MAG_W)'(-v) : v;
			m = odd ? (m >> (FRAC_BITS + 1)) : (m >> FRAC_BITS);
			s = v[MAG_W-1] ? -$signed(m) : $signed(m);
			if (s > 64'sd8191) out_pix = 14'h1fff;
			else if (s < -64'sd8192) out_pix = 14'h2000;
			else out_pix = s[PIX_OUT_W-1:0];
		end
	endfunction

endpackage

[rtl/core/bkt_div.sv]
module bkt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bkt_pkg::div_req_t  req,
	output bkt_pkg::div_rsp_t  rsp
);

	localparam int NW = bkt_pkg::DIV_NUM_W;
	localparam int DW = bkt_pkg::COV_W + 1;

	logic [NW-1:0]  quo_q;
	logic [DW:0]    rem_q;
	logic [DW-1:0]  den_q;
	logic [6:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic [DW:0]    shifted;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= {req.num, {bkt_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.gain = (quo_q > NW'(32'h7fffffff)) ? 32'h7fffffff : quo_q[bkt_pkg::POS_W-1:0];

endmodule

[rtl/core/bkt_mul.sv]
module bkt_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  bkt_pkg::mul_req_t  req,
	output bkt_pkg::mul_rsp_t  rsp
);

	localparam int AW = bkt_pkg::COV_W;

	logic [AW-1:0]    ma_q;
	logic [AW-1:0]    mb_q;
	logic             neg_q;
	logic [1:0]       ph_q;
	logic [63:0]      tl_q;
	logic [63:0]      th_q;
	logic [63:0]      m_q;
	logic [AW-1:0]    am;
	logic [AW-1:0]    bm;
	logic [63:0]      fmask;

	assign am = req.a[AW] ? AW'(-req.a) : req.a[AW-1:0];
	assign bm = req.b[AW] ? AW'(-req.b) : req.b[AW-1:0];
	assign fmask = (64'd1 << bkt_pkg::FRAC_BITS) - 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
		end else if (req.start) begin
			ph_q <= 2'd1;
		end else if (ph_q != 2'd0) begin
			ph_q <= (ph_q == 2'd3) ? 2'd0 : ph_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= am;
			mb_q <= bm;
			neg_q <= req.a[AW] ^ req.b[AW];
		end
		if (ph_q == 2'd1) tl_q <= 64'(ma_q) * 64'(mb_q[19:0]);
		if (ph_q == 2'd2) th_q <= 64'(ma_q) * 64'(mb_q[AW-1:20]);
		if (ph_q == 2'd3) begin
			if ((th_q >> bkt_pkg::FRAC_BITS) >= (64'd1 << 41))
				m_q <= 64'd1 << 61;
			else
				m_q <= ((th_q >> bkt_pkg::FRAC_BITS) << 20)
					+ ((tl_q + ((th_q & fmask) << 20)) >> bkt_pkg::FRAC_BITS);
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= (ph_q == 2'd3);
	end

	assign rsp.done = done_q;
	assign rsp.prod = neg_q ? -$signed(m_q) : $signed(m_q);

endmodule

[rtl/core/box_kalman_tracker.sv]
// init and op 3 go straight to the output; predict first runs the prediction step; update
// skips each coordinate whose innovation variance is not positive and corrects the others
// one item is processed at a time; each updated coordinate runs two 56-step gain divisions
// and five products on the shared units; a new input is taken while a result waits
// arst_n clears the filter state, the age and the handshakes; configuration registers
// reset to their defaults
module box_kalman_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // box_left, box_top, box_width, box_height
	input  logic [1:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // out_left, out_top, out_width, out_height, frames_since_update
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int PW = bkt_pkg::POS_W;
	localparam int CW = bkt_pkg::COV_W;
	localparam int MW = bkt_pkg::MAG_W;

	bkt_pkg::state_t state_q, state_d;

	logic [bkt_pkg::REG_W-1:0] q_q, r_q, iv_q;
	logic signed [PW-1:0] pos_q [4];
	logic signed [PW-1:0] rate_q [4];
	logic signed [CW-1:0] pa_q [4];
	logic signed [CW-1:0] pb_q [4];
	logic signed [CW-1:0] pc_q [4];
	logic signed [PW-1:0] z_q [4];
	logic [bkt_pkg::AGE_W-1:0] age_q;
	logic [1:0]  op_q;
	logic [1:0]  idx_q;
	logic [2:0]  mstep_q;
	logic signed [PW-1:0] k0_q, k1_q, y_q;
	logic signed [MW-1:0] m_q [5];
	logic [71:0] out_q;
	logic        out_v_q;

	bkt_pkg::div_req_t dreq;
	bkt_pkg::div_rsp_t drsp;
	bkt_pkg::mul_req_t mreq;
	bkt_pkg::mul_rsp_t mrsp;

	bkt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	bkt_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	logic signed [CW:0] s_sum;
	assign s_sum = (CW+1)'(pa_q[idx_q]) + (CW+1)'($signed({1'b0, r_q}));

	assign s_axis_tready = (state_q == bkt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bkt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dreq = '0;
		mreq = '0;
		case (state_q)
			bkt_pkg::ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) state_d = bkt_pkg::ST_LOAD;
			end
			bkt_pkg::ST_LOAD: begin
				case (bkt_pkg::op_t'(op_q))
					bkt_pkg::OP_INIT: state_d = bkt_pkg::ST_OUT_CALC;
					bkt_pkg::OP_PREDICT: state_d = bkt_pkg::ST_PRED;
					bkt_pkg::OP_UPDATE: state_d = bkt_pkg::ST_UPD_CHK;
					default: state_d = bkt_pkg::ST_OUT_CALC;
				endcase
			end
			bkt_pkg::ST_PRED: state_d = bkt_pkg::ST_OUT_CALC;
			bkt_pkg::ST_UPD_CHK: begin
				if (s_sum <= 0) state_d = bkt_pkg::ST_NEXT;
				else state_d = bkt_pkg::ST_DIV0_GO;
			end
			bkt_pkg::ST_DIV0_GO: begin
				dreq.start = 1'b1;
				dreq.num = pa_q[idx_q][CW-1] ? CW'(-pa_q[idx_q]) : pa_q[idx_q];
				dreq.den = s_sum;
				state_d = bkt_pkg::ST_DIV0_WAIT;
			end
			bkt_pkg::ST_DIV0_WAIT: if (drsp.done) state_d = bkt_pkg::ST_DIV1_GO;
			bkt_pkg::ST_DIV1_GO: begin
				dreq.start = 1'b1;
				dreq.num = pb_q[idx_q][CW-1] ? CW'(-pb_q[idx_q]) : pb_q[idx_q];
				dreq.den = s_sum;
				state_d = bkt_pkg::ST_DIV1_WAIT;
			end
			bkt_pkg::ST_DIV1_WAIT: if (drsp.done) state_d = bkt_pkg::ST_MUL_GO;
			bkt_pkg::ST_MUL_GO: begin
				mreq.start = 1'b1;
				case (mstep_q)
					3'd0: begin mreq.a = (CW+1)'(k0_q); mreq.b = (CW+1)'(y_q); end
					3'd1: begin mreq.a = (CW+1)'(k1_q); mreq.b = (CW+1)'(y_q); end
					3'd2: begin mreq.a = (CW+1)'(k0_q); mreq.b = (CW+1)'(pa_q[idx_q]); end
					3'd3: begin mreq.a = (CW+1)'(k0_q); mreq.b = (CW+1)'(pb_q[idx_q]); end
					default: begin mreq.a = (CW+1)'(k1_q); mreq.b = (CW+1)'(pb_q[idx_q]); end
				endcase
				state_d = bkt_pkg::ST_MUL_WAIT;
			end
			bkt_pkg::ST_MUL_WAIT: if (mrsp.done) state_d = bkt_pkg::ST_MUL_WB;
			bkt_pkg::ST_MUL_WB: begin
				state_d = (mstep_q == 3'd4) ? bkt_pkg::ST_UPD_WB : bkt_pkg::ST_MUL_GO;
			end
			bkt_pkg::ST_UPD_WB: state_d = bkt_pkg::ST_NEXT;
			bkt_pkg::ST_NEXT: begin
				state_d = (idx_q == 2'd3) ? bkt_pkg::ST_OUT_CALC : bkt_pkg::ST_UPD_CHK;
			end
			bkt_pkg::ST_OUT_CALC: if (!out_v_q) state_d = bkt_pkg::ST_OUT;
			bkt_pkg::ST_OUT: state_d = bkt_pkg::ST_IDLE;
			default: state_d = bkt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= 24'd655;
			r_q <= 24'd6554;
			iv_q <= 24'd65536;
			age_q <= '0;
			out_v_q <= 1'b0;
			op_q <= '0;
			idx_q <= '0;
			mstep_q <= '0;
			for (int i = 0; i < 4; i++) begin
				pos_q[i] <= '0;
				rate_q[i] <= '0;
				pa_q[i] <= '0;
				pb_q[i] <= '0;
				pc_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (bkt_pkg::reg_idx_t'(cfg_index))
					bkt_pkg::REG_PROCESS_NOISE: q_q <= cfg_data;
					bkt_pkg::REG_MEASUREMENT_NOISE: r_q <= cfg_data;
					bkt_pkg::REG_INITIAL_VARIANCE: iv_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				bkt_pkg::ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) op_q <= s_axis_tuser;
					idx_q <= '0;
				end
				bkt_pkg::ST_LOAD: begin
					if (bkt_pkg::op_t'(op_q) == bkt_pkg::OP_INIT) begin
						for (int i = 0; i < 4; i++) begin
							pos_q[i] <= z_q[i];
							rate_q[i] <= '0;
							pa_q[i] <= CW'(iv_q);
							pb_q[i] <= '0;
							pc_q[i] <= CW'(iv_q);
						end
						age_q <= '0;
					end
				end
				bkt_pkg::ST_PRED: begin
					for (int i = 0; i < 4; i++) begin
						pos_q[i] <= bkt_pkg::sat_pos(MW'(pos_q[i]) + MW'(rate_q[i]));
						pa_q[i] <= bkt_pkg::sat_cov(MW'(pa_q[i]) + (MW'(pb_q[i]) <<< 1)
							+ MW'(pc_q[i]) + $signed(MW'(q_q)));
						pb_q[i] <= bkt_pkg::sat_cov(MW'(pb_q[i]) + MW'(pc_q[i]));
						pc_q[i] <= bkt_pkg::sat_cov(MW'(pc_q[i]) + $signed(MW'(q_q)));
					end
					if (age_q != 16'hffff) age_q <= age_q + 16'd1;
				end
				bkt_pkg::ST_UPD_CHK: begin
					mstep_q <= '0;
					y_q <= bkt_pkg::sat_pos(MW'(z_q[idx_q]) - MW'(pos_q[idx_q]));
				end
				bkt_pkg::ST_DIV0_WAIT: if (drsp.done)
					k0_q <= pa_q[idx_q][CW-1] ? -$signed(drsp.gain) : $signed(drsp.gain);
				bkt_pkg::ST_DIV1_WAIT: if (drsp.done)
					k1_q <= pb_q[idx_q][CW-1] ? -$signed(drsp.gain) : $signed(drsp.gain);
				bkt_pkg::ST_MUL_WAIT: if (mrsp.done) m_q[mstep_q] <= mrsp.prod;
				bkt_pkg::ST_MUL_WB: mstep_q <= mstep_q + 3'd1;
				bkt_pkg::ST_UPD_WB: begin
					pos_q[idx_q] <= bkt_pkg::sat_pos(MW'(pos_q[idx_q]) + m_q[0]);
					rate_q[idx_q] <= bkt_pkg::sat_pos(MW'(rate_q[idx_q]) + m_q[1]);
					pa_q[idx_q] <= bkt_pkg::sat_cov(MW'(pa_q[idx_q]) - m_q[2]);
					pb_q[idx_q] <= bkt_pkg::sat_cov(MW'(pb_q[idx_q]) - m_q[3]);
					pc_q[idx_q] <= bkt_pkg::sat_cov(MW'(pc_q[idx_q]) - m_q[4]);
				end
				bkt_pkg::ST_NEXT: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) age_q <= '0;
				end
				bkt_pkg::ST_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	logic [bkt_pkg::PIXEL_BITS-1:0] in_l, in_t, in_w, in_h;
	assign in_l = s_axis_tdata[0 +: bkt_pkg::PIXEL_BITS];
	assign in_t = s_axis_tdata[12 +: bkt_pkg::PIXEL_BITS];
	assign in_w = s_axis_tdata[24 +: bkt_pkg::PIXEL_BITS];
	assign in_h = s_axis_tdata[36 +: bkt_pkg::PIXEL_BITS];

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			z_q[0] <= PW'({in_l, {bkt_pkg::FRAC_BITS{1'b0}}})
				+ PW'({in_w, {(bkt_pkg::FRAC_BITS-1){1'b0}}});
			z_q[1] <= PW'({in_t, {bkt_pkg::FRAC_BITS{1'b0}}})
				+ PW'({in_h, {(bkt_pkg::FRAC_BITS-1){1'b0}}});
			z_q[2] <= PW'({in_w, {bkt_pkg::FRAC_BITS{1'b0}}});
			z_q[3] <= PW'({in_h, {bkt_pkg::FRAC_BITS{1'b0}}});
		end
		if (state_q == bkt_pkg::ST_OUT_CALC && !out_v_q) begin
			out_q[13:0] <= bkt_pkg::out_pix((MW'(pos_q[0]) <<< 1) - MW'(pos_q[2]), 1'b1);
			out_q[27:14] <= bkt_pkg::out_pix((MW'(pos_q[1]) <<< 1) - MW'(pos_q[3]), 1'b1);
			out_q[41:28] <= bkt_pkg::out_pix(MW'(pos_q[2]), 1'b0);
			out_q[55:42] <= bkt_pkg::out_pix(MW'(pos_q[3]), 1'b0);
			out_q[71:56] <= age_q;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bkt_pkg::ST_IDLE) |-> !s_axis_tready)
		else $error("input taken while busy");
	a_out_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == bkt_pkg::ST_OUT))
		else $error("result raised out of sequence");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> (state_q == bkt_pkg::ST_DIV0_GO || state_q == bkt_pkg::ST_DIV1_GO))
		else $error("divider started out of sequence");

endmodule
